@@ src/assert_macros.svh @@
// assertion macros for the checker file
// no dependencies; include guard below
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked at every clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/sha256_pkg.sv @@
// types, round constants and hash functions for the sha-256/224 engine
// no dependencies
`default_nettype none

package sha256_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_FF,
    ST_PAD,
    ST_ZERO,
    ST_LEN,
    ST_OUT_RD,
    ST_OUT_LD
  } state_t;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] IV_256 [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] IV_224 [8] = '{
    32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
    32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
  };

  localparam logic [31:0] PAD_BYTE_WORD = 32'h80000000;

  function automatic logic [31:0] iv_word(input logic mode, input logic [2:0] idx);
    return mode ? IV_224[idx] : IV_256[idx];
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_s0(input logic [31:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_s1(input logic [31:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_s0(input logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_s1(input logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] ch(input logic [31:0] x, input logic [31:0] y,
                                     input logic [31:0] z);
    return (x & y) ^ (~x & z);
  endfunction

  function automatic logic [31:0] maj(input logic [31:0] x, input logic [31:0] y,
                                      input logic [31:0] z);
    return (x & y) ^ (x & z) ^ (y & z);
  endfunction

  // leading-byte mask for 0 to 4 valid bytes
  function automatic logic [31:0] keep_mask(input logic [2:0] n);
    logic [31:0] m;
    m = 32'h0;
    case (n)
      3'd1: m = 32'hff000000;
      3'd2: m = 32'hffff0000;
      3'd3: m = 32'hffffff00;
      3'd4: m = 32'hffffffff;
      default: m = 32'h0;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

@@ src/sha256_hash_engine.sv @@
// Streaming SHA-256 / SHA-224 engine. Message words are taken one per transfer, one per cycle,
// while the 64-byte block fills; a full block then holds the input while the engine reads the
// hash words from the hash memory, runs 64 rounds at one per cycle and does the read-add-write
// of the feed-forward. A final word adds padding and one or two more blocks, then each digest
// word leaves through an output register, read in turn through the single read port of the
// hash memory. The input is taken again once the last digest word is loaded.
// digest_mode may only be written while the engine is idle; a write restarts the message.
// depends on sha256_pkg
`default_nettype none

module sha256_hash_engine (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write_en,
  input  wire logic        digest_mode,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] message_word,
  input  wire logic [2:0]  valid_bytes,
  input  wire logic        is_last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      digest_word,
  output logic [2:0]       word_index,
  output logic             last_word
);

  sha256_pkg::state_t state, state_next;

  // control registers
  logic        mode;
  logic        fresh;
  logic [5:0]  fill;
  logic [63:0] bcount;
  logic [31:0] acc;
  logic [6:0]  cnt;
  logic [3:0]  widx;
  logic [2:0]  oidx;
  logic        finish, pad_done, len_done, blk2;

  // datapath registers
  logic [31:0] wbuf [16];
  logic [31:0] v [8];
  logic [31:0] hmem [8];
  logic [31:0] rd_data;

  logic        accept;
  logic        slot_free;
  logic [2:0]  rd_addr;
  logic        mem_we;
  logic [2:0]  mem_waddr;
  logic [31:0] mem_wdata;
  logic [31:0] ff_base;

  logic [1:0]  k;
  logic [2:0]  n;
  logic [31:0] wm;
  logic [63:0] win;
  logic [3:0]  total;
  logic [6:0]  fill_sum;
  logic        olast;
  logic        fill_hi;

  logic [31:0] t1, t2, w_new;

  assign accept    = in_valid && !in_stall;
  assign slot_free = !out_valid || !out_stall;
  assign olast     = (oidx == (mode ? 3'd6 : 3'd7));
  assign fill_hi   = (fill[5:3] == 3'b111);

  // byte packing of the incoming word behind the held partial word
  always_comb begin
    k        = fill[1:0];
    n        = (valid_bytes > 3'd4) ? 3'd4 : valid_bytes;
    wm       = message_word & sha256_pkg::keep_mask(n);
    win      = {acc, 32'h0} | ({wm, 32'h0} >> {k, 3'b000});
    total    = {2'b00, k} + {1'b0, n};
    fill_sum = {1'b0, fill} + {4'b0000, n};
  end

  // one compression round and the next schedule word
  always_comb begin
    t1 = v[7] + sha256_pkg::big_s1(v[4]) + sha256_pkg::ch(v[4], v[5], v[6])
       + sha256_pkg::ROUND_K[cnt[5:0]] + wbuf[0];
    t2 = sha256_pkg::big_s0(v[0]) + sha256_pkg::maj(v[0], v[1], v[2]);
    w_new = wbuf[0] + sha256_pkg::small_s0(wbuf[1]) + wbuf[9]
          + sha256_pkg::small_s1(wbuf[14]);
  end

  // feed-forward operand: the iv stands in for the memory after a restart
  assign ff_base = fresh ? sha256_pkg::iv_word(mode, cnt[2:0] - 3'd1) : rd_data;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sha256_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and memory control
  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    rd_addr    = 3'd0;
    mem_we     = 1'b0;
    mem_waddr  = cnt[2:0] - 3'd1;
    mem_wdata  = ff_base + v[0];
    unique case (state)
      sha256_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (accept) begin
          if (fill_sum[6]) state_next = sha256_pkg::ST_LOAD;
          else if (is_last) state_next = sha256_pkg::ST_PAD;
        end
      end
      sha256_pkg::ST_LOAD: begin
        rd_addr = cnt[2:0];
        if (cnt == 7'd8) state_next = sha256_pkg::ST_ROUND;
      end
      sha256_pkg::ST_ROUND: begin
        if (cnt == 7'd63) state_next = sha256_pkg::ST_FF;
      end
      sha256_pkg::ST_FF: begin
        rd_addr = cnt[2:0];
        mem_we  = (cnt != 7'd0);
        if (cnt == 7'd8) begin
          if (!finish) state_next = sha256_pkg::ST_IDLE;
          else if (!pad_done) state_next = sha256_pkg::ST_PAD;
          else if (!len_done) state_next = sha256_pkg::ST_ZERO;
          else state_next = sha256_pkg::ST_OUT_RD;
        end
      end
      sha256_pkg::ST_PAD: begin
        if (fill[5:2] == 4'd15) state_next = sha256_pkg::ST_LOAD;
        else state_next = sha256_pkg::ST_ZERO;
      end
      sha256_pkg::ST_ZERO: begin
        if (widx == 4'd15) begin
          if (blk2 || !fill_hi) state_next = sha256_pkg::ST_LEN;
          else state_next = sha256_pkg::ST_LOAD;
        end
      end
      sha256_pkg::ST_LEN: begin
        state_next = sha256_pkg::ST_LOAD;
      end
      sha256_pkg::ST_OUT_RD: begin
        rd_addr    = oidx;
        state_next = sha256_pkg::ST_OUT_LD;
      end
      sha256_pkg::ST_OUT_LD: begin
        rd_addr = oidx;
        if (slot_free) begin
          state_next = olast ? sha256_pkg::ST_IDLE : sha256_pkg::ST_OUT_RD;
        end
      end
      default: state_next = sha256_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= 1'b0;
      fresh     <= 1'b1;
      fill      <= 6'd0;
      bcount    <= 64'd0;
      acc       <= 32'h0;
      cnt       <= 7'd0;
      widx      <= 4'd0;
      oidx      <= 3'd0;
      finish    <= 1'b0;
      pad_done  <= 1'b0;
      len_done  <= 1'b0;
      blk2      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        // mode write restarts the message
        mode   <= digest_mode;
        fresh  <= 1'b1;
        fill   <= 6'd0;
        bcount <= 64'd0;
        acc    <= 32'h0;
      end else begin
        case (state)
          sha256_pkg::ST_IDLE: begin
            cnt <= 7'd0;
            if (accept) begin
              fill     <= fill_sum[5:0];
              bcount   <= bcount + {61'd0, n};
              acc      <= total[2] ? win[31:0] : win[63:32];
              finish   <= is_last;
              pad_done <= 1'b0;
              len_done <= 1'b0;
              blk2     <= 1'b0;
            end
          end
          sha256_pkg::ST_LOAD, sha256_pkg::ST_ROUND: begin
            cnt <= (state_next == state) ? cnt + 7'd1 : 7'd0;
          end
          sha256_pkg::ST_FF: begin
            cnt <= (state_next == state) ? cnt + 7'd1 : 7'd0;
            if (cnt == 7'd8) begin
              fresh <= 1'b0;
              oidx  <= 3'd0;
              if (finish && pad_done && !len_done) begin
                widx <= 4'd0;
                blk2 <= 1'b1;
              end
            end
          end
          sha256_pkg::ST_PAD: begin
            pad_done <= 1'b1;
            widx     <= fill[5:2] + 4'd1;
            cnt      <= 7'd0;
          end
          sha256_pkg::ST_ZERO: begin
            widx <= widx + 4'd1;
            cnt  <= 7'd0;
          end
          sha256_pkg::ST_LEN: begin
            len_done <= 1'b1;
            cnt      <= 7'd0;
          end
          sha256_pkg::ST_OUT_LD: begin
            if (slot_free) begin
              if (olast) begin
                fresh  <= 1'b1;
                fill   <= 6'd0;
                bcount <= 64'd0;
                acc    <= 32'h0;
                finish <= 1'b0;
              end else begin
                oidx <= oidx + 3'd1;
              end
            end
          end
          default: begin
          end
        endcase
      end

      // output register: loaded from the hash memory, cleared on transfer
      if (state == sha256_pkg::ST_OUT_LD && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // hash word memory, one read and one write port
  always_ff @(posedge clk) begin
    rd_data <= hmem[rd_addr];
    if (mem_we) hmem[mem_waddr] <= mem_wdata;
  end

  // block buffer, working variables and output payload
  always_ff @(posedge clk) begin
    case (state)
      sha256_pkg::ST_IDLE: begin
        if (accept && total[2]) wbuf[fill[5:2]] <= win[63:32];
      end
      sha256_pkg::ST_LOAD: begin
        if (cnt != 7'd0) begin
          for (int i = 0; i < 7; i++) v[i] <= v[i + 1];
          v[7] <= fresh ? sha256_pkg::iv_word(mode, cnt[2:0] - 3'd1) : rd_data;
        end
      end
      sha256_pkg::ST_ROUND: begin
        v[0] <= t1 + t2;
        v[1] <= v[0];
        v[2] <= v[1];
        v[3] <= v[2];
        v[4] <= v[3] + t1;
        v[5] <= v[4];
        v[6] <= v[5];
        v[7] <= v[6];
        for (int i = 0; i < 15; i++) wbuf[i] <= wbuf[i + 1];
        wbuf[15] <= w_new;
      end
      sha256_pkg::ST_FF: begin
        if (cnt != 7'd0) begin
          for (int i = 0; i < 7; i++) v[i] <= v[i + 1];
        end
      end
      sha256_pkg::ST_PAD: begin
        wbuf[fill[5:2]] <= acc | (sha256_pkg::PAD_BYTE_WORD >> {k, 3'b000});
      end
      sha256_pkg::ST_ZERO: begin
        wbuf[widx] <= 32'h0;
      end
      sha256_pkg::ST_LEN: begin
        wbuf[14] <= bcount[60:29];
        wbuf[15] <= {bcount[28:0], 3'b000};
      end
      sha256_pkg::ST_OUT_LD: begin
        if (slot_free) begin
          digest_word <= rd_data;
          word_index  <= oidx;
          last_word   <= olast;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

@@ src/sha256_check.sv @@
// port-level checks for the sha-256/224 engine, bound into the engine module
// depends on assert_macros.svh and sha256_hash_engine
`default_nettype none
`include "assert_macros.svh"

module sha256_check (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] digest_word,
  input wire logic [2:0]  word_index,
  input wire logic        last_word
);

  // a stalled digest word holds until its transfer
  `ASSERT_CLK(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(digest_word) && $stable(word_index) && $stable(last_word), "stalled digest word changed")

  // the eighth word always ends the digest
  `ASSERT_CLK(a_idx_last, clk, rst, out_valid && word_index == 3'd7 |-> last_word, "word 7 without last flag")

  // no new message is taken while the digest is still being read out
  `ASSERT_CLK(a_busy_out, clk, rst, out_valid && !last_word |-> in_stall, "input taken mid digest")

  // reset leaves no result pending
  `ASSERT_ALWAYS(a_rst_empty, clk, $past(rst) |-> !out_valid, "result valid after reset")

endmodule

bind sha256_hash_engine sha256_check u_check (.*);

`default_nettype wire
